// ===== rtl/core/multi_slot_second_timer_top_macros.svh =====
// ----------------------------------------------------------------------------
// multi_slot_second_timer_top_macros.svh
// Assertion macros shared by the timer modules.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_SECOND_TIMER_TOP_MACROS_SVH
`define MULTI_SLOT_SECOND_TIMER_TOP_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define MST_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define MST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and constants of the multi-slot second timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mst_pkg;

    // Width of the slot field on the ports
    localparam int SLOT_W = 3;
    // Most events reported for one tick transaction
    localparam int MAX_RESULTS = 8;
    // Register value after reset
    localparam logic [31:0] TPS_RESET = 32'd1000000;

    // Item codes of the func field
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    // One slot entry in the state memory
    typedef struct packed {
        logic [31:0] ticks;
        logic [15:0] secs;
        logic        en;
    } slot_ent_t;

    // Event stream from the slot scan to the output stage
    typedef struct packed {
        logic              ev;
        logic              done;
        logic [SLOT_W-1:0] slot;
        logic              fin;
    } mst_evt_t;

endpackage

`default_nettype wire

// ===== rtl/core/mst_scan.sv =====
// ----------------------------------------------------------------------------
// mst_scan
// Slot state memory and the sequencer that starts slots and walks all slots
// on each tick with a read-modify-write per slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multi_slot_second_timer_top_macros.svh"

module mst_scan #(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        func,
    input  wire logic [mst_pkg::SLOT_W-1:0]  slot,
    input  wire logic [15:0]                 seconds,
    input  wire logic                        per_second_enable,
    input  wire logic [31:0]                 reload,
    output mst_pkg::mst_evt_t                evt,
    input  wire logic                        ev_ready
);
    import mst_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int AW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_END
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [NUM_SLOTS-1:0]   active_reg, active_next;

    slot_ent_t              mem [NUM_SLOTS];
    slot_ent_t              rd_reg;

    logic                   accept;
    logic                   start_ok;
    logic [AW-1:0]          slot_ext;
    logic [AW-1:0]          idx_ext;
    logic [31:0]            dec_ticks;
    logic [15:0]            dec_secs;
    logic                   cur_active;
    logic                   sec_end;
    logic                   slot_done;
    logic                   eval_go;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    slot_ent_t              wr_data;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // Decode the start target and the slot being evaluated
    assign slot_ext   = AW'(slot);
    assign idx_ext    = AW'(idx_reg);
    assign start_ok   = accept && (func == FUNC_START) && ({29'd0, slot} < 32'(NUM_SLOTS));

    // Evaluate the entry registered in the read state
    assign dec_ticks  = rd_reg.ticks - 32'd1;
    assign dec_secs   = rd_reg.secs - 16'd1;
    assign cur_active = active_reg[idx_reg];
    assign sec_end    = cur_active && (dec_ticks == 32'd0);
    assign slot_done  = sec_end && (dec_secs == 16'd0);

    always_comb
    begin
        evt      = '0;
        evt.ev   = (state_reg == S_EVAL) && sec_end && (slot_done || rd_reg.en);
        evt.fin  = slot_done;
        evt.slot = idx_ext[SLOT_W-1:0];
        evt.done = (state_reg == S_END);
    end

    assign eval_go = (state_reg == S_EVAL) && (!evt.ev || ev_ready);

    // Select the write-back of a start or of an evaluated slot
    always_comb
    begin
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_reg;
        active_next = active_reg;
        if (start_ok)
        begin
            wr_en         = 1'b1;
            wr_addr       = slot_ext[IDX_W-1:0];
            wr_data.ticks = reload;
            wr_data.secs  = (seconds == 16'd0) ? 16'd1 : seconds;
            wr_data.en    = per_second_enable;
            active_next[slot_ext[IDX_W-1:0]] = 1'b1;
        end
        else if (eval_go && cur_active)
        begin
            if (slot_done)
            begin
                active_next[idx_reg] = 1'b0;
            end
            else
            begin
                wr_en         = 1'b1;
                wr_data.ticks = sec_end ? reload : dec_ticks;
                wr_data.secs  = sec_end ? dec_secs : rd_reg.secs;
            end
        end
    end

    // Sequence the scan
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (func == FUNC_TICK))
                begin
                    state_next = S_READ;
                    idx_next   = '0;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (eval_go)
                begin
                    if (idx_reg == IDX_W'(NUM_SLOTS - 1))
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        state_next = S_READ;
                        idx_next   = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_END:
            begin
                if (ev_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, scan index and active flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            active_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            active_reg <= active_next;
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == S_READ)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    `MST_ASSERT_NEXT(a_tick_starts_at_zero, accept && (func == FUNC_TICK),
        (idx_reg == '0) && (state_reg == S_READ), "tick did not start scan at slot zero")
    `MST_ASSERT_ALWAYS(a_event_from_active, !evt.ev || cur_active,
        "event raised for an inactive slot")
    `MST_ASSERT_NEXT(a_hold_on_stall, evt.ev && !ev_ready,
        $stable(idx_reg) && (state_reg == S_EVAL), "scan advanced while event stalled")
    `MST_ASSERT_ALWAYS(a_no_start_in_scan, !(wr_en && start_ok) || (state_reg == S_IDLE),
        "start write outside idle")

endmodule

`default_nettype wire

// ===== rtl/core/mst_emit.sv =====
// ----------------------------------------------------------------------------
// mst_emit
// Output stage: holds one pending event so the last one of a tick can be
// marked, caps the events per tick and drives the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multi_slot_second_timer_top_macros.svh"

module mst_emit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mst_pkg::mst_evt_t           evt,
    output logic                             ev_ready,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [mst_pkg::SLOT_W-1:0]       event_slot,
    output logic                             final_res,
    output logic                             last
);
    import mst_pkg::*;

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    logic               pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]  pend_slot_reg, pend_slot_next;
    logic               pend_fin_reg, pend_fin_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic               out_fin_reg, out_fin_next;
    logic               out_last_reg, out_last_next;

    logic               out_free;
    logic               can_take;
    logic               push;
    logic               push_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign can_take = (count_reg < CNT_W'(MAX_RESULTS));

    // Merge events into the pending slot and push the previous one out
    always_comb
    begin
        ev_ready        = 1'b1;
        push            = 1'b0;
        push_last       = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_fin_next   = pend_fin_reg;
        count_next      = count_reg;
        if (evt.done)
        begin
            if (pend_valid_reg)
            begin
                ev_ready = out_free;
                if (out_free)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                end
            end
            else
            begin
                count_next = '0;
            end
        end
        else if (evt.ev)
        begin
            if (!pend_valid_reg)
            begin
                pend_valid_next = 1'b1;
                pend_slot_next  = evt.slot;
                pend_fin_next   = evt.fin;
                count_next      = CNT_W'(1);
            end
            else if (can_take)
            begin
                ev_ready = out_free;
                if (out_free)
                begin
                    push           = 1'b1;
                    pend_slot_next = evt.slot;
                    pend_fin_next  = evt.fin;
                    count_next     = count_reg + CNT_W'(1);
                end
            end
        end
    end

    // Load or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_slot_next  = out_slot_reg;
        out_fin_next   = out_fin_reg;
        out_last_next  = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_slot_next  = pend_slot_reg;
            out_fin_next   = pend_fin_reg;
            out_last_next  = push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        pend_fin_reg  <= pend_fin_next;
        out_slot_reg  <= out_slot_next;
        out_fin_reg   <= out_fin_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign event_slot = out_slot_reg;
    assign final_res  = out_fin_reg;
    assign last       = out_last_reg;

    `MST_ASSERT_ALWAYS(a_count_cap, count_reg <= CNT_W'(MAX_RESULTS),
        "event count above cap")
    `MST_ASSERT_ALWAYS(a_pend_matches_count, pend_valid_reg == (count_reg != '0),
        "pending flag and event count disagree")
    `MST_ASSERT_NEXT(a_end_clears, evt.done && ev_ready,
        !pend_valid_reg && (count_reg == '0), "tick end left a pending event")

endmodule

`default_nettype wire

// ===== rtl/core/multi_slot_second_timer_top.sv =====
// A bank of NUM_SLOTS one-shot timers counted in whole seconds. A start
// transaction (func = 1) loads a slot and gives no event. A tick transaction
// (func = 0) walks every slot through the slot memory with one read and at
// most one write-back per slot; the scan holds while an event waits on a
// stalled output. Events of one tick leave in slot order, at most eight of
// them, and the final one carries last. Write ticks_per_second only while no
// tick is in progress; a value of 0 acts as 1.
// ----------------------------------------------------------------------------
// multi_slot_second_timer_top
// Top level: configuration register, slot scan and event output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_second_timer_top #(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [31:0]                 cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        func,
    input  wire logic [mst_pkg::SLOT_W-1:0]  slot,
    input  wire logic [15:0]                 seconds,
    input  wire logic                        per_second_enable,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [mst_pkg::SLOT_W-1:0]       event_slot,
    output logic                             final_res,
    output logic                             last
);
    import mst_pkg::*;

    logic [31:0]  tps_reg;
    logic [31:0]  reload;
    mst_evt_t     evt;
    logic         ev_ready;

    // Hold the ticks-per-second register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tps_reg <= cfg_data;
        end
    end

    // Treat a zero period as one tick
    assign reload = (tps_reg == 32'd0) ? 32'd1 : tps_reg;

    mst_scan #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_scan (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .func              (func),
        .slot              (slot),
        .seconds           (seconds),
        .per_second_enable (per_second_enable),
        .reload            (reload),
        .evt               (evt),
        .ev_ready          (ev_ready)
    );

    mst_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .ev_ready   (ev_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_slot (event_slot),
        .final_res  (final_res),
        .last       (last)
    );

endmodule

`default_nettype wire
